### design/cau_pkg.sv
// cau_pkg: shared types, codes and helpers of the complex arithmetic unit
// no dependencies; used by every file in design/
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  // remainder / wide intermediate width: sums of two products plus sign
  localparam int RW         = 2 * DATA_WIDTH + 2;

  localparam logic [2:0] KIND_ADD  = 3'd0;
  localparam logic [2:0] KIND_SUB  = 3'd1;
  localparam logic [2:0] KIND_MUL  = 3'd2;
  localparam logic [2:0] KIND_DIV  = 3'd3;
  localparam logic [2:0] KIND_SCL  = 3'd4;
  localparam logic [2:0] KIND_RDIV = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [2:0]                   kind;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic [1:0]                   status;
  } out_item_t;

  // state handed from one divider cell to the next
  typedef struct packed {
    logic                  valid;
    logic                  is_div;
    logic                  neg_r;
    logic                  neg_i;
    logic [RW-1:0]         d;
    logic [RW-1:0]         rem_r;
    logic [RW-1:0]         rem_i;
    logic [DATA_WIDTH-1:0] q_r;
    logic [DATA_WIDTH-1:0] q_i;
    logic                  big_r;
    logic                  big_i;
    out_item_t             pass;
  } cell_t;

  localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // clamp a wide signed value to the data range; bit DATA_WIDTH = saturated
  function automatic logic [DATA_WIDTH:0] clamp(input logic signed [RW-1:0] x);
    logic signed [RW-1:0] back;
    logic [DATA_WIDTH:0]  r;
    back = RW'(signed'(x[DATA_WIDTH-1:0]));
    if (back == x) r = {1'b0, x[DATA_WIDTH-1:0]};
    else if (x[RW-1]) r = {1'b1, SAT_MIN};
    else r = {1'b1, SAT_MAX};
    return r;
  endfunction

  // apply sign to a quotient magnitude; bit DATA_WIDTH = saturated
  function automatic logic [DATA_WIDTH:0] fin_quot(input logic [DATA_WIDTH-1:0] q,
                                                   input logic big, input logic neg);
    logic [DATA_WIDTH:0] r;
    if (neg) begin
      if (big || (q[DATA_WIDTH-1] && (|q[DATA_WIDTH-2:0]))) r = {1'b1, SAT_MIN};
      else r = {1'b0, DATA_WIDTH'(-q)};
    end else begin
      if (big || q[DATA_WIDTH-1]) r = {1'b1, SAT_MAX};
      else r = {1'b0, q};
    end
    return r;
  endfunction

endpackage

### design/complex_arith_unit.sv
// complex_arith_unit: complex add/sub/mul/div/scale/real-divide on signed fixed point
// each beat passes the input register, the product register, the row of divider
// cells (one quotient bit per cell) and the output register; one beat accepted every cycle
// busy is always low and the receiver cannot stall; results leave in order
// reset (synchronous, rst_n low) clears all valid flags; no pending beat survives
// depends on cau_pkg, cau_div_cell
module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cau_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cau_pkg::out_item_t out_item
);

  localparam int W       = cau_pkg::DATA_WIDTH;
  localparam int RW      = cau_pkg::RW;
  localparam int NUM_W   = RW + FRAC_BITS;
  localparam int LATENCY = NUM_W + 3;

  assign busy = 1'b0;

  // stage 1: input register
  logic              s1_valid_r;
  cau_pkg::in_item_t s1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else s1_valid_r <= start;
  end

  always_ff @(posedge clk) begin
    s1_r <= in_item;
  end

  // stage 2: products
  logic                  s2_valid_r;
  cau_pkg::in_item_t     s2_r;
  logic signed [2*W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, p_bb_r, p_cc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else s2_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    s2_r   <= s1_r;
    p_rr_r <= s1_r.a_real * s1_r.b_real;
    p_ii_r <= s1_r.a_imag * s1_r.b_imag;
    p_ir_r <= s1_r.a_imag * s1_r.b_real;
    p_ri_r <= s1_r.a_real * s1_r.b_imag;
    p_bb_r <= s1_r.b_real * s1_r.b_real;
    p_cc_r <= s1_r.b_imag * s1_r.b_imag;
  end

  // sums, numerators and divisor; feeds the first cell
  logic signed [RW-1:0] ar, ai, br, bi, e_rr, e_ii, e_ir, e_ri, e_bb, e_cc;
  logic signed [RW-1:0] rr, ri, nr, ni, dv;
  logic [RW-1:0]        mag_r, mag_i, mag_d;
  logic [W:0]           cl_r, cl_i;
  logic                 div_k;
  cau_pkg::cell_t       head;
  logic [NUM_W-1:0]     head_nr, head_ni;

  always_comb begin
    ar   = RW'(s2_r.a_real);
    ai   = RW'(s2_r.a_imag);
    br   = RW'(s2_r.b_real);
    bi   = RW'(s2_r.b_imag);
    e_rr = RW'(p_rr_r);
    e_ii = RW'(p_ii_r);
    e_ir = RW'(p_ir_r);
    e_ri = RW'(p_ri_r);
    e_bb = RW'(p_bb_r);
    e_cc = RW'(p_cc_r);
    rr    = '0;
    ri    = '0;
    nr    = ar;
    ni    = ai;
    dv    = br;
    div_k = 1'b0;
    unique case (s2_r.kind)
      cau_pkg::KIND_ADD: begin
        rr = ar + br;
        ri = ai + bi;
      end
      cau_pkg::KIND_SUB: begin
        rr = ar - br;
        ri = ai - bi;
      end
      cau_pkg::KIND_MUL: begin
        rr = (e_rr - e_ii) >>> FRAC_BITS;
        ri = (e_ir + e_ri) >>> FRAC_BITS;
      end
      cau_pkg::KIND_DIV: begin
        nr    = e_rr + e_ii;
        ni    = e_ir - e_ri;
        dv    = e_bb + e_cc;
        div_k = 1'b1;
      end
      cau_pkg::KIND_SCL: begin
        rr = e_rr >>> FRAC_BITS;
        ri = e_ir >>> FRAC_BITS;
      end
      cau_pkg::KIND_RDIV: begin
        div_k = 1'b1;
      end
      default: begin
        rr = '0;
        ri = '0;
      end
    endcase
    mag_r = nr[RW-1] ? RW'(-nr) : RW'(nr);
    mag_i = ni[RW-1] ? RW'(-ni) : RW'(ni);
    mag_d = dv[RW-1] ? RW'(-dv) : RW'(dv);
    cl_r  = cau_pkg::clamp(rr);
    cl_i  = cau_pkg::clamp(ri);

    head        = '0;
    head.valid  = s2_valid_r;
    head.d      = mag_d;
    head.neg_r  = nr[RW-1] ^ dv[RW-1];
    head.neg_i  = ni[RW-1] ^ dv[RW-1];
    if (div_k && dv == '0) begin
      // divide by zero: saturate by dividend sign
      head.pass.res_real = nr[RW-1] ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
      head.pass.res_imag = ni[RW-1] ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
      head.pass.status   = cau_pkg::ST_DIVZ;
    end else if (div_k) begin
      head.is_div = 1'b1;
    end else begin
      head.pass.res_real = cl_r[W-1:0];
      head.pass.res_imag = cl_i[W-1:0];
      head.pass.status   = (cl_r[W] || cl_i[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
    head_nr = {mag_r, {FRAC_BITS{1'b0}}};
    head_ni = {mag_i, {FRAC_BITS{1'b0}}};
  end

  // row of divider cells
  cau_pkg::cell_t   ch   [0:NUM_W];
  logic [NUM_W-1:0] ch_nr[0:NUM_W];
  logic [NUM_W-1:0] ch_ni[0:NUM_W];

  assign ch[0]    = head;
  assign ch_nr[0] = head_nr;
  assign ch_ni[0] = head_ni;

  for (genvar g = 0; g < NUM_W; g++) begin : g_cell
    cau_div_cell #(.NUM_W(NUM_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .c_in   (ch[g]),
      .nr_in  (ch_nr[g]),
      .ni_in  (ch_ni[g]),
      .c_out  (ch[g+1]),
      .nr_out (ch_nr[g+1]),
      .ni_out (ch_ni[g+1])
    );
  end

  // sign and saturate the quotients, output register
  cau_pkg::cell_t     tail;
  logic [W:0]         fq_r, fq_i;
  cau_pkg::out_item_t res_nxt, res_r;
  logic               out_valid_r;

  always_comb begin
    tail = ch[NUM_W];
    fq_r = cau_pkg::fin_quot(tail.q_r, tail.big_r, tail.neg_r);
    fq_i = cau_pkg::fin_quot(tail.q_i, tail.big_i, tail.neg_i);
    if (tail.is_div) begin
      res_nxt.res_real = fq_r[W-1:0];
      res_nxt.res_imag = fq_i[W-1:0];
      res_nxt.status   = (fq_r[W] || fq_i[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end else begin
      res_nxt = tail.pass;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= tail.valid;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = res_r;

endmodule

### design/cau_div_cell.sv
// cau_div_cell: one restoring-division step for both lanes, registered
// depends on cau_pkg
module cau_div_cell #(
  parameter int NUM_W = cau_pkg::RW + cau_pkg::FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cau_pkg::cell_t        c_in,
  input  logic [NUM_W-1:0]      nr_in,
  input  logic [NUM_W-1:0]      ni_in,
  output cau_pkg::cell_t        c_out,
  output logic [NUM_W-1:0]      nr_out,
  output logic [NUM_W-1:0]      ni_out
);

  cau_pkg::cell_t         c_r, c_nxt;
  logic                   valid_r;
  logic [NUM_W-1:0]       nr_r, ni_r;
  logic [cau_pkg::RW-1:0] rs_r, rs_i;
  logic                   qb_r, qb_i;

  // shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    c_nxt = c_in;
    rs_r  = {c_in.rem_r[cau_pkg::RW-2:0], nr_in[NUM_W-1]};
    rs_i  = {c_in.rem_i[cau_pkg::RW-2:0], ni_in[NUM_W-1]};
    qb_r  = (rs_r >= c_in.d);
    qb_i  = (rs_i >= c_in.d);
    c_nxt.rem_r = qb_r ? rs_r - c_in.d : rs_r;
    c_nxt.rem_i = qb_i ? rs_i - c_in.d : rs_i;
    c_nxt.q_r   = {c_in.q_r[cau_pkg::DATA_WIDTH-2:0], qb_r};
    c_nxt.q_i   = {c_in.q_i[cau_pkg::DATA_WIDTH-2:0], qb_i};
    c_nxt.big_r = c_in.big_r | c_in.q_r[cau_pkg::DATA_WIDTH-1];
    c_nxt.big_i = c_in.big_i | c_in.q_i[cau_pkg::DATA_WIDTH-1];
  end

  // valid is control, the rest is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= c_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    c_r  <= c_nxt;
    nr_r <= nr_in << 1;
    ni_r <= ni_in << 1;
  end

  // payload with the reset-cleared valid flag
  always_comb begin
    c_out       = c_r;
    c_out.valid = valid_r;
  end

  assign nr_out = nr_r;
  assign ni_out = ni_r;

endmodule

### design/cau_checker.sv
// cau_checker: port-level checks of complex_arith_unit, bound to the top level
// depends on cau_pkg and complex_arith_unit
module cau_checker #(
  parameter int LAT = 3
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input cau_pkg::out_item_t out_item
);

  // never holds off a beat
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every accepted beat comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("result missing at fixed latency");

  // only defined status codes leave
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == cau_pkg::ST_OK ||
                   out_item.status == cau_pkg::ST_SAT ||
                   out_item.status == cau_pkg::ST_DIVZ))
    else $error("undefined status");

  // divide by zero always gives saturated parts
  a_divz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == cau_pkg::ST_DIVZ) |->
      ((out_item.res_real == cau_pkg::SAT_MAX || out_item.res_real == cau_pkg::SAT_MIN) &&
       (out_item.res_imag == cau_pkg::SAT_MAX || out_item.res_imag == cau_pkg::SAT_MIN)))
    else $error("divide by zero result not saturated");

endmodule

bind complex_arith_unit cau_checker #(.LAT(LATENCY)) u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

### tb/tb_top.sv
// tb_top: self-checking testbench for complex_arith_unit
// directed and random beats checked against a wide-integer predictor
// depends on cau_pkg and the design files
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  localparam int LATENCY    = 2 * cau_pkg::DATA_WIDTH + 2 + cau_pkg::FRAC_BITS + 3;
  localparam int IDLE_LIMIT = 4000;
  localparam int N_RANDOM   = 880;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  cau_pkg::in_item_t  in_item;
  logic               out_valid;
  cau_pkg::out_item_t out_item;

  cau_pkg::out_item_t expected_q[$];
  int                 n_errors;
  int                 n_sent;
  int                 n_checked;
  int                 idle_cycles;
  int                 kind_hits[8];

  complex_arith_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // clamp one wide value to the data range, flag saturation
  function automatic logic [cau_pkg::DATA_WIDTH-1:0] clamp_part(input wide_t x,
                                                                inout bit sat);
    wide_t hi, lo;
    hi = wide_t'($signed(cau_pkg::SAT_MAX));
    lo = wide_t'($signed(cau_pkg::SAT_MIN));
    if (x > hi) begin
      sat = 1'b1;
      return cau_pkg::SAT_MAX;
    end
    if (x < lo) begin
      sat = 1'b1;
      return cau_pkg::SAT_MIN;
    end
    return x[cau_pkg::DATA_WIDTH-1:0];
  endfunction

  // expected result of one operation
  function automatic cau_pkg::out_item_t complex_result(input cau_pkg::in_item_t it);
    wide_t ar, ai, br, bi, rr, ri, nr, ni, den;
    bit sat, dz;
    cau_pkg::out_item_t r;
    ar = $signed(it.a_real);
    ai = $signed(it.a_imag);
    br = $signed(it.b_real);
    bi = $signed(it.b_imag);
    rr = '0;
    ri = '0;
    nr = '0;
    ni = '0;
    den = '0;
    sat = 1'b0;
    dz = 1'b0;
    case (it.kind)
      cau_pkg::KIND_ADD: begin
        rr = ar + br;
        ri = ai + bi;
      end
      cau_pkg::KIND_SUB: begin
        rr = ar - br;
        ri = ai - bi;
      end
      cau_pkg::KIND_MUL: begin
        rr = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
        ri = (ai * br + ar * bi) >>> cau_pkg::FRAC_BITS;
      end
      cau_pkg::KIND_DIV, cau_pkg::KIND_RDIV: begin
        if (it.kind == cau_pkg::KIND_DIV) begin
          nr = ar * br + ai * bi;
          ni = ai * br - ar * bi;
          den = br * br + bi * bi;
        end else begin
          nr = ar;
          ni = ai;
          den = br;
        end
        if (den == 0) dz = 1'b1;
        else begin
          rr = (nr <<< cau_pkg::FRAC_BITS) / den;
          ri = (ni <<< cau_pkg::FRAC_BITS) / den;
        end
      end
      cau_pkg::KIND_SCL: begin
        rr = (ar * br) >>> cau_pkg::FRAC_BITS;
        ri = (ai * br) >>> cau_pkg::FRAC_BITS;
      end
      default: ;
    endcase
    if (dz) begin
      r.res_real = nr < 0 ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
      r.res_imag = ni < 0 ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
      r.status = cau_pkg::ST_DIVZ;
    end else begin
      r.res_real = clamp_part(rr, sat);
      r.res_imag = clamp_part(ri, sat);
      r.status = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
    return r;
  endfunction

  // send one beat after a gap; start stays high when the next gap is zero
  task automatic send_op(input cau_pkg::in_item_t it, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    expected_q.push_back(complex_result(it));
    kind_hits[it.kind]++;
    n_sent++;
  endtask

  function automatic cau_pkg::in_item_t make_op(input logic [2:0] k,
                                                input logic [31:0] a_r,
                                                input logic [31:0] a_i,
                                                input logic [31:0] b_r,
                                                input logic [31:0] b_i);
    cau_pkg::in_item_t it;
    it.kind = k;
    it.a_real = a_r;
    it.a_imag = a_i;
    it.b_real = b_r;
    it.b_imag = b_i;
    return it;
  endfunction

  // operand with extremes, small values and zeros mixed in
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return cau_pkg::SAT_MAX;
      1: return cau_pkg::SAT_MIN;
      2: return '0;
      3, 4: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // let the pipeline empty with start low
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(make_op(cau_pkg::KIND_ADD, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN,
                    cau_pkg::SAT_MAX, cau_pkg::SAT_MIN), 0);
    send_op(make_op(cau_pkg::KIND_ADD, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000,
                    32'h0000_4000), 0);
    send_op(make_op(cau_pkg::KIND_SUB, cau_pkg::SAT_MIN, cau_pkg::SAT_MAX,
                    cau_pkg::SAT_MAX, cau_pkg::SAT_MIN), 1);
    send_op(make_op(cau_pkg::KIND_SUB, 32'h0003_0000, 32'h0, 32'h0001_0000,
                    32'h0001_0000), 0);
    send_op(make_op(cau_pkg::KIND_MUL, 32'h0002_0000, 32'h0003_0000, 32'hfffe_0000,
                    32'h0001_8000), 0);
    send_op(make_op(cau_pkg::KIND_MUL, cau_pkg::SAT_MIN, cau_pkg::SAT_MIN,
                    cau_pkg::SAT_MIN, cau_pkg::SAT_MIN), 2);
    send_op(make_op(cau_pkg::KIND_MUL, 32'hffff_ffff, 32'h1, 32'h1, 32'h1), 0);
    send_op(make_op(cau_pkg::KIND_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                    32'hffff_0000), 0);
    send_op(make_op(cau_pkg::KIND_DIV, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, 32'h1,
                    32'h0), 0);
    send_op(make_op(cau_pkg::KIND_DIV, 32'h0, 32'hffff_0000, 32'h0, 32'h0), 3);
    send_op(make_op(cau_pkg::KIND_DIV, cau_pkg::SAT_MIN, cau_pkg::SAT_MAX, 32'h0,
                    32'h0), 0);
    send_op(make_op(cau_pkg::KIND_DIV, cau_pkg::SAT_MIN, cau_pkg::SAT_MIN,
                    cau_pkg::SAT_MIN, cau_pkg::SAT_MIN), 0);
    send_op(make_op(cau_pkg::KIND_SCL, 32'h0001_8000, 32'hffff_8000, 32'h0002_0000,
                    32'h1234), 0);
    send_op(make_op(cau_pkg::KIND_SCL, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN,
                    cau_pkg::SAT_MIN, 32'h0), 1);
    send_op(make_op(cau_pkg::KIND_RDIV, 32'h0005_0000, 32'hfffb_0000, 32'h0002_0000,
                    32'hdead), 0);
    send_op(make_op(cau_pkg::KIND_RDIV, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, 32'h1,
                    32'h0), 0);
    send_op(make_op(cau_pkg::KIND_RDIV, 32'h0, 32'h8000_0001, 32'h0, 32'h5), 0);
    send_op(make_op(cau_pkg::KIND_RDIV, 32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h0), 0);
    send_op(make_op(3'd6, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, 32'h1, 32'h1), 0);
    send_op(make_op(3'd7, 32'h1234_5678, 32'h9abc_def0, 32'h0, 32'h0), 0);
  endtask

  task automatic test_random(input int n_ops);
    cau_pkg::in_item_t it;
    int gap;
    for (int i = 0; i < n_ops; i++) begin
      it.kind = 3'($urandom_range(0, 7));
      it.a_real = rand_operand();
      it.a_imag = rand_operand();
      it.b_real = rand_operand();
      it.b_imag = rand_operand();
      // stretches of back-to-back beats between gappy ones
      gap = ((i / 64) % 2 == 0) ? $urandom_range(0, 8) : 0;
      send_op(it, gap);
    end
  endtask

  // sender holds off until the pipeline is empty, then resumes
  task automatic test_pause_midstream();
    test_random(10);
    drain();
    test_random(10);
  endtask

  // result checker
  always @(posedge clk) begin
    cau_pkg::out_item_t exp_item;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with none expected: got %h", $time, out_item);
        n_errors++;
      end else begin
        exp_item = expected_q.pop_front();
        n_checked++;
        if (out_item.res_real !== exp_item.res_real) begin
          $display("%0t: res_real expected %h actual %h", $time, exp_item.res_real,
                   out_item.res_real);
          n_errors++;
        end
        if (out_item.res_imag !== exp_item.res_imag) begin
          $display("%0t: res_imag expected %h actual %h", $time, exp_item.res_imag,
                   out_item.res_imag);
          n_errors++;
        end
        if (out_item.status !== exp_item.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_item.status,
                   out_item.status);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    idle_cycles = 0;
    foreach (kind_hits[k]) kind_hits[k] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pause_midstream();
    test_random(N_RANDOM);
    drain();

    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      n_errors++;
    end
    $display("covered %0d beats, %0d results checked; per kind: %0d %0d %0d %0d %0d %0d %0d %0d",
             n_sent, n_checked, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
             kind_hits[4], kind_hits[5], kind_hits[6], kind_hits[7]);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
